// File: hdl/pled_pkg.sv
// Shared constants and types for the port LED status store.
// No dependencies; imported by every module of the block.
package pled_pkg;

    localparam int TOP_PORTS    = 16;
    localparam int BOTTOM_PORTS = 32;
    localparam int ALL_PORTS    = TOP_PORTS + BOTTOM_PORTS;

    localparam int PORT_W  = 6;
    localparam int CH_W    = 3;
    localparam int FIELD_W = 5;
    localparam int FIELDS  = 6;
    localparam int WORD_W  = FIELD_W * FIELDS;
    localparam int LANES   = 4;
    localparam int LANE_W  = $clog2(LANES);

    // Port arithmetic runs one bit wider so that twice a port still fits.
    localparam int PNUM_W = PORT_W + 1;

    localparam int TOP_IW = (TOP_PORTS > 1) ? $clog2(TOP_PORTS) : 1;
    localparam int BOT_IW = $clog2(BOTTOM_PORTS);

    // Field holding the partner color in a bottom word; lane fields start after it.
    localparam int PARTNER_FIELD = 1;
    localparam int LANE_FIELD0   = 2;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;
    localparam int CQ_CW    = 2;

    typedef logic [WORD_W-1:0]  t_led_word;
    typedef logic [FIELD_W-1:0] t_color;

    typedef enum logic {
        OP_SET = 1'b0,
        OP_GET = 1'b1
    } t_op;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        t_op               op;
        logic              bad;
        logic              is_top;
        logic              partner_ok;
        logic [TOP_IW-1:0] top_idx;
        logic [BOT_IW-1:0] bot_idx;
        logic [BOT_IW-1:0] partner_idx;
        logic [LANE_W-1:0] lane;
        t_color            color;
    } t_cmd;

endpackage

// File: hdl/pled_front.sv
// Request classifier: range checks and store index computation.
// Depends on pled_pkg.
module pled_front import pled_pkg::*; (
    input  logic              i_operation,
    input  logic [PORT_W-1:0] i_port,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [FIELD_W-1:0] i_color,
    output t_cmd              o_cmd
);

    logic [PNUM_W-1:0] port_ext;
    logic [PNUM_W-1:0] bot_off;
    logic [PNUM_W-1:0] partner;
    logic              is_top;
    logic              is_bot;

    always_comb begin
        port_ext = {1'b0, i_port};
        bot_off  = port_ext - PNUM_W'(TOP_PORTS);
        partner  = port_ext << 1;
        is_top   = port_ext < PNUM_W'(TOP_PORTS);
        is_bot   = !is_top && (port_ext < PNUM_W'(ALL_PORTS));

        o_cmd.op          = t_op'(i_operation);
        o_cmd.bad         = !(is_top || is_bot) || (i_channel >= CH_W'(LANES));
        o_cmd.is_top      = is_top;
        o_cmd.partner_ok  = partner < PNUM_W'(BOTTOM_PORTS);
        o_cmd.top_idx     = i_port[TOP_IW-1:0];
        o_cmd.bot_idx     = bot_off[BOT_IW-1:0];
        o_cmd.partner_idx = partner[BOT_IW-1:0];
        o_cmd.lane        = i_channel[LANE_W-1:0];
        o_cmd.color       = i_color;
    end

endmodule

// File: hdl/pled_cmd_queue.sv
// Short command queue between the classifier and the store engine.
// Depends on pled_pkg.
module pled_cmd_queue import pled_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CQ_CW'(CQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CQ_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CQ_CW'(1);
                2'b01:   r_count <= r_count - CQ_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hdl/pled_back.sv
// Store engine: LED word stores, one read-modify-write per command, result register.
// Depends on pled_pkg.
module pled_back import pled_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [FIELD_W-1:0] o_led_color,
    output logic               o_bad_request
);

    localparam int FSEL_W = $clog2(FIELDS);

    function automatic t_led_word put_field(t_led_word word, logic [FSEL_W-1:0] n,
                                            t_color val);
        t_led_word w;
        w = word;
        for (int f = 0; f < FIELDS; f++) begin
            if (n == FSEL_W'(f)) begin
                w[f*FIELD_W +: FIELD_W] = val;
            end
        end
        return w;
    endfunction

    function automatic t_color get_field(t_led_word word, logic [FSEL_W-1:0] n);
        t_color v;
        v = '0;
        for (int f = 0; f < FIELDS; f++) begin
            if (n == FSEL_W'(f)) begin
                v = word[f*FIELD_W +: FIELD_W];
            end
        end
        return v;
    endfunction

    t_led_word r_top [TOP_PORTS];
    t_led_word r_bot [BOTTOM_PORTS];

    logic         r_res_valid;
    t_color       r_led_color;
    logic         r_bad;

    logic              take;
    logic              is_set;
    logic              top_we;
    logic              bot_we;
    logic [BOT_IW-1:0] bot_idx;
    logic [FSEL_W-1:0] lane_field;
    t_led_word         top_rd;
    t_led_word         bot_rd;
    t_led_word         top_wd;
    t_led_word         bot_wd;
    t_led_word         lane_wd;
    t_color            n_led_color;

    always_comb begin
        take       = i_cmd_valid && (!r_res_valid || i_pop);
        is_set     = (i_cmd.op == OP_SET);
        bot_idx    = i_cmd.is_top ? i_cmd.partner_idx : i_cmd.bot_idx;
        lane_field = FSEL_W'(i_cmd.lane) + FSEL_W'(LANE_FIELD0);
        top_rd     = r_top[i_cmd.top_idx];
        bot_rd     = r_bot[bot_idx];

        // Top set: color everywhere but the partner field.
        top_wd = '0;
        for (int f = 0; f < FIELDS; f++) begin
            if (f != PARTNER_FIELD) begin
                top_wd[f*FIELD_W +: FIELD_W] = i_cmd.color;
            end
        end

        lane_wd = put_field(bot_rd, lane_field, i_cmd.color);
        if (i_cmd.lane == '0) begin
            lane_wd = put_field(lane_wd, '0, i_cmd.color);
        end
        bot_wd = i_cmd.is_top ? put_field(bot_rd, FSEL_W'(PARTNER_FIELD), i_cmd.color)
                              : lane_wd;

        top_we = take && !i_cmd.bad && is_set && i_cmd.is_top;
        bot_we = take && !i_cmd.bad && is_set && (!i_cmd.is_top || i_cmd.partner_ok);

        n_led_color = '0;
        if (!i_cmd.bad && !is_set) begin
            n_led_color = get_field(i_cmd.is_top ? top_rd : bot_rd, lane_field);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOP_PORTS; i++) begin
                r_top[i] <= '0;
            end
            for (int i = 0; i < BOTTOM_PORTS; i++) begin
                r_bot[i] <= '0;
            end
            r_res_valid <= 1'b0;
        end else begin
            if (top_we) begin
                r_top[i_cmd.top_idx] <= top_wd;
            end
            if (bot_we) begin
                r_bot[bot_idx] <= bot_wd;
            end
            if (take) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_led_color <= n_led_color;
            r_bad       <= i_cmd.bad;
        end
    end

    assign o_cmd_pop     = take;
    assign o_empty       = !r_res_valid;
    assign o_led_color   = r_led_color;
    assign o_bad_request = r_bad;

endmodule

// File: hdl/port_led_status_register_file_core.sv
// Top level of the front-panel port LED status store.
// Depends on pled_pkg, pled_front, pled_cmd_queue and pled_back.

// Holds one 30-bit LED word (six 5-bit color fields) for each of 16 top and
// 32 bottom ports and answers set and get requests, one result beat per
// request beat, in order. Both sides are queue-like: push a request while
// o_full is low, pop a result while o_empty is low. A pushed request passes
// through the command queue and then the result register before it shows on
// the ports; the sustained rate is one request per clock while results are
// popped as they appear, and the store engine does one read-modify-write per
// request on its flip-flop word stores. A two-entry command queue between the
// classifier and the engine keeps requests flowing while a result waits to be
// popped. Reset clears all LED words in the same cycle; no clearing pass
// follows. Requests naming a port above 47 or a channel above 3 come back
// flagged with a zero color and leave the store untouched.
module port_led_status_register_file_core import pled_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_operation,
    input  logic [PORT_W-1:0]  i_port,
    input  logic [CH_W-1:0]    i_channel,
    input  logic [FIELD_W-1:0] i_color,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [FIELD_W-1:0] o_led_color,
    output logic               o_bad_request
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_pop;

    // Classify the incoming beat: range checks and store indexes.
    pled_front u_front (
        .i_operation (i_operation),
        .i_port      (i_port),
        .i_channel   (i_channel),
        .i_color     (i_color),
        .o_cmd       (front_cmd)
    );

    // Buffer classified requests so the engine can stall on the result side.
    pled_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // Execute against the LED word stores and register the result beat.
    pled_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (queue_valid),
        .i_cmd         (queue_cmd),
        .o_cmd_pop     (queue_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_led_color   (o_led_color),
        .o_bad_request (o_bad_request)
    );

    // A queued command with a free result slot must show up as a result next cycle.
    a_drain_into_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (queue_valid && o_empty) |=> !o_empty)
        else $error("queued command did not reach the result register");

    // A flagged result never carries a color.
    a_bad_has_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_bad_request) |-> (o_led_color == '0))
        else $error("flagged result carries a nonzero color");

    // Leaving reset, both sides start drained.
    a_reset_drained: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (o_empty && !o_full && !queue_valid))
        else $error("block not drained after reset");

    // The queue can only be full while the engine is held by a waiting result.
    a_full_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("command queue full while result register is free");

endmodule
